FILE: rtl/dcp_pkg.sv
// dcp_pkg: shared constants, codes, command and status types, saturating add helper
// used by the interfaces, the controller, the datapath, the top level and the checker
package dcp_pkg;

  // default sizes of the graph stores
  localparam int unsigned MAX_NODES_DEF   = 1024;
  localparam int unsigned MAX_EDGES_DEF   = 4096;
  localparam int unsigned WEIGHT_BITS_DEF = 20;

  // fixed field widths
  localparam int OP_W  = 3;
  localparam int IDX_W = 10;
  localparam int AMT_W = 20;
  localparam int NC_W  = 11;
  localparam int ST_W  = 3;
  localparam int VAL_W = 32;

  // operation codes
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
  localparam logic [OP_W-1:0] OP_SET_W   = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD_E   = 3'd2;
  localparam logic [OP_W-1:0] OP_COMPUTE = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY   = 3'd4;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_CYCLE    = 3'd1;
  localparam logic [ST_W-1:0] ST_FITS     = 3'd2;
  localparam logic [ST_W-1:0] ST_LATE     = 3'd3;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd4;

  // controller states
  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_Q_OUT, S_DONE,
    S_INIT_RD, S_INIT_WR,
    S_DEG_RD, S_DEG_CHK, S_DEG_WR,
    S_SEED_RD, S_SEED_WR,
    S_POP, S_POP_U, S_POP_R, S_FW_RD, S_FW_CHK, S_FW_WR,
    S_BK_POP, S_BK_U, S_BK_R, S_BK_SCAN, S_BK_CHK, S_BK_UPD
  } state_e;

  // datapath micro commands
  typedef enum logic [4:0] {
    C_NOP, C_ACCEPT, C_CLEAR, C_SETW, C_ADDE, C_Q_RD, C_Q_OUT,
    C_START, C_INIT_RD, C_INIT_WR, C_EDGE_RD, C_DEG_RD, C_DEG_INC,
    C_SEED_START, C_SEED_RD, C_SEED_PUSH, C_CYCLE, C_POP_RD, C_U_RD,
    C_REACH, C_FW_RD, C_FW_WR, C_BACK_START, C_BK_RD, C_BK_U,
    C_BK_INIT, C_BK_WR, C_LO_RD, C_BK_UPD, C_FINISH, C_OUT_LOAD
  } cmd_e;

  // datapath status seen by the controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            query_ok;
    logic            i_end;
    logic            i_zero;
    logic            e_end;
    logic            edge_in;
    logic            edge_from_u;
    logic            q_empty;
    logic            all_done;
  } dp_sts_t;

  // clamp a sum to 32 bits
  function automatic logic [31:0] sat32(input logic [33:0] s);
    logic [31:0] r;
    r = (s > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    return r;
  endfunction

endpackage

FILE: rtl/dcp_intf.sv
// dcp_intf: valid/ready channel interfaces for input items and results
// depends on dcp_pkg for field widths
interface dcp_in_if;
  logic                        valid;
  logic                        ready;
  logic [dcp_pkg::OP_W-1:0]    operation;
  logic [dcp_pkg::IDX_W-1:0]   node_index;
  logic [dcp_pkg::IDX_W-1:0]   target_node;
  logic [dcp_pkg::AMT_W-1:0]   amount;
  modport source (output valid, operation, node_index, target_node, amount, input ready);
  modport sink   (input valid, operation, node_index, target_node, amount, output ready);
endinterface

interface dcp_out_if;
  logic                        valid;
  logic                        ready;
  logic [dcp_pkg::ST_W-1:0]    status;
  logic [dcp_pkg::VAL_W-1:0]   value;
  modport source (output valid, status, value, input ready);
  modport sink   (input valid, status, value, output ready);
endinterface

FILE: rtl/dag_critical_path_slack_check_unit.sv
// compute: init, in-degree count, seeding and the forward and backward passes over n nodes
//   and E stored edges; each processed node rescans the edge list memory
// throughput: one item at a time; the next item is taken once the current one has finished
// reset: asynchronous active low; graph stores are not cleared, counters and flags are
module dag_critical_path_slack_check_unit #(
  parameter int unsigned MAX_NODES   = dcp_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_EDGES   = dcp_pkg::MAX_EDGES_DEF,
  parameter int unsigned WEIGHT_BITS = dcp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [dcp_pkg::NC_W-1:0] cfg_wdata_i,
  dcp_in_if.sink                   in_ch,
  dcp_out_if.source                out_ch
);
  import dcp_pkg::*;

  cmd_e    cmd;
  dp_sts_t sts;

  // sequencer
  dcp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // memories and arithmetic
  dcp_datapath #(
    .MAX_NODES   (MAX_NODES),
    .MAX_EDGES   (MAX_EDGES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .operation_i   (in_ch.operation),
    .node_index_i  (in_ch.node_index),
    .target_node_i (in_ch.target_node),
    .amount_i      (in_ch.amount),
    .status_o      (out_ch.status),
    .value_o       (out_ch.value)
  );

endmodule

FILE: rtl/dcp_ctrl.sv
// dcp_ctrl: sequencer state machine, handshakes and micro command issue
// depends on dcp_pkg
module dcp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  dcp_pkg::dp_sts_t sts_i,
  output dcp_pkg::cmd_e    cmd_o
);
  import dcp_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // state and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // next state and command
  always_comb begin
    state_d     = state_q;
    cmd_o       = C_NOP;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = C_ACCEPT;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = S_IDLE;
        case (sts_i.op)
          OP_CLEAR: cmd_o = C_CLEAR;
          OP_SET_W: cmd_o = C_SETW;
          OP_ADD_E: cmd_o = C_ADDE;
          OP_COMPUTE: begin
            cmd_o   = C_START;
            state_d = S_INIT_RD;
          end
          OP_QUERY: begin
            if (sts_i.query_ok) begin
              cmd_o   = C_Q_RD;
              state_d = S_Q_OUT;
            end
          end
          default: cmd_o = C_NOP;
        endcase
      end
      S_Q_OUT: begin
        cmd_o   = C_Q_OUT;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o       = C_OUT_LOAD;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      // node table init
      S_INIT_RD: begin
        if (sts_i.i_end) begin
          state_d = S_DEG_RD;
        end else begin
          cmd_o   = C_INIT_RD;
          state_d = S_INIT_WR;
        end
      end
      S_INIT_WR: begin
        cmd_o   = C_INIT_WR;
        state_d = S_INIT_RD;
      end
      // in-degree count over the edge list
      S_DEG_RD: begin
        if (sts_i.e_end) begin
          cmd_o   = C_SEED_START;
          state_d = S_SEED_RD;
        end else begin
          cmd_o   = C_EDGE_RD;
          state_d = S_DEG_CHK;
        end
      end
      S_DEG_CHK: begin
        if (sts_i.edge_in) begin
          cmd_o   = C_DEG_RD;
          state_d = S_DEG_WR;
        end else begin
          state_d = S_DEG_RD;
        end
      end
      S_DEG_WR: begin
        cmd_o   = C_DEG_INC;
        state_d = S_DEG_RD;
      end
      // queue every source node
      S_SEED_RD: begin
        if (sts_i.i_end) begin
          state_d = S_POP;
        end else begin
          cmd_o   = C_SEED_RD;
          state_d = S_SEED_WR;
        end
      end
      S_SEED_WR: begin
        cmd_o   = C_SEED_PUSH;
        state_d = S_SEED_RD;
      end
      // forward pass in topological order
      S_POP: begin
        if (sts_i.q_empty) begin
          if (sts_i.all_done) begin
            cmd_o   = C_BACK_START;
            state_d = S_BK_POP;
          end else begin
            cmd_o   = C_CYCLE;
            state_d = S_DONE;
          end
        end else begin
          cmd_o   = C_POP_RD;
          state_d = S_POP_U;
        end
      end
      S_POP_U: begin
        cmd_o   = C_U_RD;
        state_d = S_POP_R;
      end
      S_POP_R: begin
        cmd_o   = C_REACH;
        state_d = S_FW_RD;
      end
      S_FW_RD: begin
        if (sts_i.e_end) begin
          state_d = S_POP;
        end else begin
          cmd_o   = C_EDGE_RD;
          state_d = S_FW_CHK;
        end
      end
      S_FW_CHK: begin
        if (sts_i.edge_from_u) begin
          cmd_o   = C_FW_RD;
          state_d = S_FW_WR;
        end else begin
          state_d = S_FW_RD;
        end
      end
      S_FW_WR: begin
        cmd_o   = C_FW_WR;
        state_d = S_FW_RD;
      end
      // backward pass in reverse topological order
      S_BK_POP: begin
        if (sts_i.i_zero) begin
          cmd_o   = C_FINISH;
          state_d = S_DONE;
        end else begin
          cmd_o   = C_BK_RD;
          state_d = S_BK_U;
        end
      end
      S_BK_U: begin
        cmd_o   = C_BK_U;
        state_d = S_BK_R;
      end
      S_BK_R: begin
        cmd_o   = C_BK_INIT;
        state_d = S_BK_SCAN;
      end
      S_BK_SCAN: begin
        if (sts_i.e_end) begin
          cmd_o   = C_BK_WR;
          state_d = S_BK_POP;
        end else begin
          cmd_o   = C_EDGE_RD;
          state_d = S_BK_CHK;
        end
      end
      S_BK_CHK: begin
        if (sts_i.edge_from_u) begin
          cmd_o   = C_LO_RD;
          state_d = S_BK_UPD;
        end else begin
          state_d = S_BK_SCAN;
        end
      end
      S_BK_UPD: begin
        cmd_o   = C_BK_UPD;
        state_d = S_BK_SCAN;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/dcp_datapath.sv
// dcp_datapath: graph memories, counters, path arithmetic and result registers
// depends on dcp_pkg; driven by micro commands from dcp_ctrl
module dcp_datapath #(
  parameter int unsigned MAX_NODES   = dcp_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_EDGES   = dcp_pkg::MAX_EDGES_DEF,
  parameter int unsigned WEIGHT_BITS = dcp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dcp_pkg::cmd_e              cmd_i,
  output dcp_pkg::dp_sts_t           sts_o,
  input  logic                       cfg_we_i,
  input  logic [dcp_pkg::NC_W-1:0]   cfg_wdata_i,
  input  logic [dcp_pkg::OP_W-1:0]   operation_i,
  input  logic [dcp_pkg::IDX_W-1:0]  node_index_i,
  input  logic [dcp_pkg::IDX_W-1:0]  target_node_i,
  input  logic [dcp_pkg::AMT_W-1:0]  amount_i,
  output logic [dcp_pkg::ST_W-1:0]   status_o,
  output logic [dcp_pkg::VAL_W-1:0]  value_o
);
  import dcp_pkg::*;

  localparam int NAW = $clog2(MAX_NODES);
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int WB  = WEIGHT_BITS;

  // memories
  logic [WB-1:0]    w_mem    [MAX_NODES];
  logic [2*NAW-1:0] edge_mem [MAX_EDGES];
  logic [31:0]      es_mem   [MAX_NODES];
  logic [31:0]      lo_mem   [MAX_NODES];
  logic [ECW-1:0]   dg_mem   [MAX_NODES];
  logic [NAW-1:0]   ord_mem  [MAX_NODES];

  // registered read data
  logic [WB-1:0]    w_rd;
  logic [2*NAW-1:0] e_rd;
  logic [31:0]      es_rd, lo_rd;
  logic [ECW-1:0]   dg_rd;
  logic [NAW-1:0]   ord_rd;

  // port controls
  logic             w_we, w_re, e_we, e_re, es_we, es_re, lo_we, lo_re;
  logic             dg_we, dg_re, ord_we, ord_re;
  logic [NAW-1:0]   w_wa, w_ra, es_wa, es_ra, lo_wa, lo_ra, dg_wa, dg_ra, ord_wa, ord_ra;
  logic [EAW-1:0]   e_wa, e_ra;
  logic [WB-1:0]    w_wd;
  logic [2*NAW-1:0] e_wd;
  logic [31:0]      es_wd, lo_wd;
  logic [ECW-1:0]   dg_wd;
  logic [NAW-1:0]   ord_wd;

  // control state
  logic [NC_W-1:0]  ncount_q;
  logic [ECW-1:0]   etot_q;
  logic             ovf_q, cyc_q;
  logic [31:0]      crit_q;
  logic [NCW-1:0]   i_q, head_q, tail_q;
  logic [ECW-1:0]   e_q;

  // payload registers
  logic [OP_W-1:0]  op_q;
  logic [IDX_W-1:0] node_q, tgt_q;
  logic [AMT_W-1:0] amt_q;
  logic [NAW-1:0]   u_q;
  logic [WB-1:0]    wu_q;
  logic [31:0]      reach_q, best_q;
  logic [ST_W-1:0]  res_st_q, out_st_q;
  logic [31:0]      res_val_q, out_val_q;

  // derived values
  logic [NCW-1:0]   n_eff;
  logic             node_ok, tgt_ok, edges_full;
  logic [NAW-1:0]   node_a, tgt_a, i_a, i_m1_a, head_a, tail_a, e_src, e_tgt;
  logic [33:0]      q_sum;
  logic             q_fit;
  logic [31:0]      q_ex, reach_c, bk_c, es_max;

  // effective node count clamped to 1..MAX_NODES
  always_comb begin
    if (ncount_q == '0) begin
      n_eff = NCW'(1);
    end else if (32'(ncount_q) > 32'(MAX_NODES)) begin
      n_eff = NCW'(MAX_NODES);
    end else begin
      n_eff = NCW'(ncount_q);
    end
  end

  assign node_ok    = 32'(node_q) < 32'(MAX_NODES);
  assign tgt_ok     = 32'(tgt_q) < 32'(MAX_NODES);
  assign edges_full = 32'(etot_q) >= 32'(MAX_EDGES);
  assign node_a     = NAW'(node_q);
  assign tgt_a      = NAW'(tgt_q);
  assign i_a        = i_q[NAW-1:0];
  assign i_m1_a     = NAW'(i_q - NCW'(1));
  assign head_a     = head_q[NAW-1:0];
  assign tail_a     = tail_q[NAW-1:0];
  assign e_src      = e_rd[2*NAW-1:NAW];
  assign e_tgt      = e_rd[NAW-1:0];

  // path arithmetic
  assign q_sum   = 34'(es_rd) + 34'(lo_rd) + 34'(amt_q);
  assign q_fit   = q_sum <= 34'(crit_q);
  assign q_ex    = sat32(q_sum - 34'(crit_q));
  assign reach_c = sat32(34'(es_rd) + 34'(w_rd));
  assign bk_c    = sat32(34'(lo_rd) + 34'(wu_q));
  assign es_max  = (reach_q > es_rd) ? reach_q : es_rd;

  // status to the controller
  always_comb begin
    sts_o.op          = op_q;
    sts_o.query_ok    = !cyc_q && (32'(node_q) < 32'(n_eff));
    sts_o.i_end       = (i_q == n_eff);
    sts_o.i_zero      = (i_q == '0);
    sts_o.e_end       = (e_q == etot_q);
    sts_o.edge_in     = (NCW'(e_src) < n_eff) && (NCW'(e_tgt) < n_eff);
    sts_o.edge_from_u = (e_src == u_q) && (NCW'(e_tgt) < n_eff);
    sts_o.q_empty     = (head_q == tail_q);
    sts_o.all_done    = (tail_q == n_eff);
  end

  // memory port decode
  always_comb begin
    w_we = 1'b0;  w_re = 1'b0;  w_wa = '0;  w_ra = '0;  w_wd = '0;
    e_we = 1'b0;  e_re = 1'b0;  e_wa = '0;  e_ra = '0;  e_wd = '0;
    es_we = 1'b0; es_re = 1'b0; es_wa = '0; es_ra = '0; es_wd = '0;
    lo_we = 1'b0; lo_re = 1'b0; lo_wa = '0; lo_ra = '0; lo_wd = '0;
    dg_we = 1'b0; dg_re = 1'b0; dg_wa = '0; dg_ra = '0; dg_wd = '0;
    ord_we = 1'b0; ord_re = 1'b0; ord_wa = '0; ord_ra = '0; ord_wd = '0;
    case (cmd_i)
      C_SETW: begin
        w_we = node_ok;
        w_wa = node_a;
        w_wd = WB'(amt_q);
      end
      C_ADDE: begin
        e_we = node_ok && tgt_ok && !edges_full;
        e_wa = etot_q[EAW-1:0];
        e_wd = {node_a, tgt_a};
      end
      C_Q_RD: begin
        es_re = 1'b1; es_ra = node_a;
        lo_re = 1'b1; lo_ra = node_a;
      end
      C_INIT_RD: begin
        w_re  = 1'b1; w_ra  = i_a;
        es_we = 1'b1; es_wa = i_a; es_wd = '0;
        dg_we = 1'b1; dg_wa = i_a; dg_wd = '0;
      end
      C_INIT_WR: begin
        lo_we = 1'b1; lo_wa = i_a; lo_wd = 32'(w_rd);
      end
      C_EDGE_RD: begin
        e_re = 1'b1; e_ra = e_q[EAW-1:0];
      end
      C_DEG_RD: begin
        dg_re = 1'b1; dg_ra = e_tgt;
      end
      C_DEG_INC: begin
        dg_we = 1'b1; dg_wa = e_tgt; dg_wd = dg_rd + ECW'(1);
      end
      C_SEED_RD: begin
        dg_re = 1'b1; dg_ra = i_a;
      end
      C_SEED_PUSH: begin
        ord_we = (dg_rd == '0); ord_wa = tail_a; ord_wd = i_a;
      end
      C_POP_RD: begin
        ord_re = 1'b1; ord_ra = head_a;
      end
      C_U_RD: begin
        w_re  = 1'b1; w_ra  = ord_rd;
        es_re = 1'b1; es_ra = ord_rd;
      end
      C_FW_RD: begin
        dg_re = 1'b1; dg_ra = e_tgt;
        es_re = 1'b1; es_ra = e_tgt;
      end
      C_FW_WR: begin
        dg_we  = 1'b1; dg_wa = e_tgt; dg_wd = dg_rd - ECW'(1);
        es_we  = 1'b1; es_wa = e_tgt; es_wd = es_max;
        ord_we = (dg_rd == ECW'(1)); ord_wa = tail_a; ord_wd = e_tgt;
      end
      C_BK_RD: begin
        ord_re = 1'b1; ord_ra = i_m1_a;
      end
      C_BK_U: begin
        w_re  = 1'b1; w_ra  = ord_rd;
        lo_re = 1'b1; lo_ra = ord_rd;
      end
      C_LO_RD: begin
        lo_re = 1'b1; lo_ra = e_tgt;
      end
      C_BK_WR: begin
        lo_we = 1'b1; lo_wa = u_q; lo_wd = best_q;
      end
      default: ;
    endcase
  end

  // weight memory
  always_ff @(posedge clk_i) begin
    if (w_we) w_mem[w_wa] <= w_wd;
    if (w_re) w_rd <= w_mem[w_ra];
  end

  // edge list memory
  always_ff @(posedge clk_i) begin
    if (e_we) edge_mem[e_wa] <= e_wd;
    if (e_re) e_rd <= edge_mem[e_ra];
  end

  // earliest start memory
  always_ff @(posedge clk_i) begin
    if (es_we) es_mem[es_wa] <= es_wd;
    if (es_re) es_rd <= es_mem[es_ra];
  end

  // longest onward memory
  always_ff @(posedge clk_i) begin
    if (lo_we) lo_mem[lo_wa] <= lo_wd;
    if (lo_re) lo_rd <= lo_mem[lo_ra];
  end

  // in-degree memory
  always_ff @(posedge clk_i) begin
    if (dg_we) dg_mem[dg_wa] <= dg_wd;
    if (dg_re) dg_rd <= dg_mem[dg_ra];
  end

  // topological order memory, used as the work queue
  always_ff @(posedge clk_i) begin
    if (ord_we) ord_mem[ord_wa] <= ord_wd;
    if (ord_re) ord_rd <= ord_mem[ord_ra];
  end

  // graph control state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncount_q <= NC_W'(1);
      etot_q   <= '0;
      ovf_q    <= 1'b0;
      cyc_q    <= 1'b1;
      crit_q   <= '0;
      i_q      <= '0;
      e_q      <= '0;
      head_q   <= '0;
      tail_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        ncount_q <= cfg_wdata_i;
        cyc_q    <= 1'b1;
      end
      case (cmd_i)
        C_CLEAR: begin
          etot_q <= '0;
          ovf_q  <= 1'b0;
          crit_q <= '0;
          cyc_q  <= 1'b1;
        end
        C_ADDE: begin
          if (node_ok && tgt_ok) begin
            if (edges_full) ovf_q <= 1'b1;
            else etot_q <= etot_q + ECW'(1);
          end
        end
        C_START: begin
          i_q    <= '0;
          e_q    <= '0;
          head_q <= '0;
          tail_q <= '0;
          crit_q <= '0;
        end
        C_INIT_WR:    i_q <= i_q + NCW'(1);
        C_EDGE_RD:    e_q <= e_q + ECW'(1);
        C_SEED_START: i_q <= '0;
        C_SEED_PUSH: begin
          i_q <= i_q + NCW'(1);
          if (dg_rd == '0) tail_q <= tail_q + NCW'(1);
        end
        C_CYCLE: begin
          cyc_q  <= 1'b1;
          crit_q <= '0;
        end
        C_POP_RD:     head_q <= head_q + NCW'(1);
        C_REACH:      e_q <= '0;
        C_FW_WR: begin
          if (dg_rd == ECW'(1)) tail_q <= tail_q + NCW'(1);
        end
        C_BACK_START: i_q <= tail_q;
        C_BK_RD:      i_q <= i_q - NCW'(1);
        C_BK_INIT:    e_q <= '0;
        C_BK_WR: begin
          if (best_q > crit_q) crit_q <= best_q;
        end
        C_FINISH:     cyc_q <= 1'b0;
        default: ;
      endcase
    end
  end

  // item, path and result payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      C_ACCEPT: begin
        op_q   <= operation_i;
        node_q <= node_index_i;
        tgt_q  <= target_node_i;
        amt_q  <= amount_i;
      end
      C_Q_OUT: begin
        res_st_q  <= q_fit ? ST_FITS : ST_LATE;
        res_val_q <= q_fit ? '0 : q_ex;
      end
      C_CYCLE: begin
        res_st_q  <= ST_CYCLE;
        res_val_q <= '0;
      end
      C_U_RD:    u_q     <= ord_rd;
      C_REACH:   reach_q <= reach_c;
      C_BK_U:    u_q     <= ord_rd;
      C_BK_INIT: begin
        wu_q   <= w_rd;
        best_q <= lo_rd;
      end
      C_BK_UPD: begin
        if (bk_c > best_q) best_q <= bk_c;
      end
      C_FINISH: begin
        res_st_q  <= ovf_q ? ST_OVERFLOW : ST_OK;
        res_val_q <= ovf_q ? '0 : crit_q;
      end
      C_OUT_LOAD: begin
        out_st_q  <= res_st_q;
        out_val_q <= res_val_q;
      end
      default: ;
    endcase
  end

  assign status_o = out_st_q;
  assign value_o  = out_val_q;

endmodule

FILE: rtl/dcp_checker.sv
// dcp_checker: port level assertions on the slack check unit
// depends on dcp_pkg; attached to the top level by the bind below
module dcp_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [dcp_pkg::ST_W-1:0]  status_i,
  input logic [dcp_pkg::VAL_W-1:0] value_i
);
  import dcp_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(status_i) && $stable(value_i))
    else $error("result payload changed while stalled");

  // one transaction in flight: input closes after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second transaction taken while busy");

  // only defined status codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i <= ST_OVERFLOW)
    else $error("undefined status code");

  // value is zero unless ok or late
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_CYCLE || status_i == ST_FITS || status_i == ST_OVERFLOW)
      |-> value_i == '0)
    else $error("nonzero value with this status");

endmodule

bind dag_critical_path_slack_check_unit dcp_checker u_dcp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .status_i    (out_ch.status),
  .value_i     (out_ch.value)
);

FILE: dv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for the task graph critical path slack checker
// depends on dcp_pkg, the dcp_in_if / dcp_out_if interfaces and the top level rtl
module tb;
  import dcp_pkg::*;

  localparam int unsigned NODE_CAP = MAX_NODES_DEF;
  localparam int unsigned EDGE_CAP = MAX_EDGES_DEF;
  localparam logic [OP_W-1:0] OP_NOISE_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_NOISE_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_NOISE_HI  = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] node;
    logic [IDX_W-1:0] target;
    logic [AMT_W-1:0] amount;
  } graph_item_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [VAL_W-1:0] value;
  } slack_result_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [NC_W-1:0] cfg_wdata_i = '0;

  dcp_in_if  in_ch ();
  dcp_out_if out_ch ();

  dag_critical_path_slack_check_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch.sink),
    .out_ch      (out_ch.source)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // graph and schedule state mirrored by the predictor
  int unsigned     node_limit;
  logic [19:0]     node_weight [NODE_CAP];
  int unsigned     edge_from [EDGE_CAP];
  int unsigned     edge_to [EDGE_CAP];
  int unsigned     edge_count;
  bit              edge_lost;
  logic [31:0]     start_time [NODE_CAP];
  logic [31:0]     tail_length [NODE_CAP];
  logic [31:0]     crit_length;
  bit              schedule_stale;

  graph_item_t     pending_items[$];
  slack_result_t   slack_expect[$];
  int              fail_count = 0;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  bit              hold_ready = 1'b0;
  bit              pressure_go = 1'b0;
  bit              in_taken = 1'b0;
  int              random_items = 0;

  function automatic int unsigned active_nodes();
    int unsigned n;
    n = node_limit;
    if (n < 1) n = 1;
    if (n > NODE_CAP) n = NODE_CAP;
    return n;
  endfunction

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // cycle search then forward and backward longest path passes
  function automatic slack_result_t schedule_graph();
    int unsigned   n, fc, sp, root, u, v, i, k, s, t;
    int unsigned   adj_begin [NODE_CAP+1];
    int unsigned   adj_fill [NODE_CAP];
    int unsigned   adj_dest [EDGE_CAP];
    bit [1:0]      mark [NODE_CAP];
    int unsigned   order [NODE_CAP];
    int unsigned   stk_node [NODE_CAP];
    int unsigned   stk_pos [NODE_CAP];
    logic [31:0]   reach, c;
    bit            looped;
    slack_result_t r;
    n = active_nodes();
    for (i = 0; i <= NODE_CAP; i++) adj_begin[i] = 0;
    for (i = 0; i < edge_count; i++) begin
      s = edge_from[i]; t = edge_to[i];
      if (s < n && t < n) adj_begin[s+1]++;
    end
    for (u = 0; u < n; u++) adj_begin[u+1] += adj_begin[u];
    for (u = 0; u < n; u++) adj_fill[u] = adj_begin[u];
    for (i = 0; i < edge_count; i++) begin
      s = edge_from[i]; t = edge_to[i];
      if (s < n && t < n) begin
        adj_dest[adj_fill[s]] = t;
        adj_fill[s]++;
      end
    end
    // depth-first search on an explicit stack
    for (i = 0; i < NODE_CAP; i++) mark[i] = 2'd0;
    looped = 1'b0;
    fc = 0;
    for (root = 0; root < n && !looped; root++) begin
      if (mark[root] == 2'd0) begin
        mark[root] = 2'd1;
        stk_node[0] = root;
        stk_pos[0] = adj_begin[root];
        sp = 1;
        while (sp > 0 && !looped) begin
          u = stk_node[sp-1];
          if (stk_pos[sp-1] < adj_begin[u+1]) begin
            v = adj_dest[stk_pos[sp-1]];
            stk_pos[sp-1]++;
            if (mark[v] == 2'd1) looped = 1'b1;
            else if (mark[v] == 2'd0 && sp < NODE_CAP) begin
              mark[v] = 2'd1;
              stk_node[sp] = v;
              stk_pos[sp] = adj_begin[v];
              sp++;
            end
          end else begin
            mark[u] = 2'd2;
            if (fc < NODE_CAP) begin
              order[fc] = u;
              fc++;
            end
            sp--;
          end
        end
      end
    end
    if (looped) begin
      schedule_stale = 1'b1;
      crit_length = '0;
      r.status = ST_CYCLE;
      r.value = '0;
      return r;
    end
    for (i = 0; i < n; i++) begin
      start_time[i] = '0;
      tail_length[i] = {12'd0, node_weight[i]};
    end
    // forward pass in reverse finish order
    for (i = fc; i > 0; i--) begin
      u = order[i-1];
      reach = sat_sum(start_time[u], {12'd0, node_weight[u]});
      for (k = adj_begin[u]; k < adj_begin[u+1]; k++)
        if (reach > start_time[adj_dest[k]]) start_time[adj_dest[k]] = reach;
    end
    // backward pass in finish order
    for (i = 0; i < fc; i++) begin
      u = order[i];
      for (k = adj_begin[u]; k < adj_begin[u+1]; k++) begin
        c = sat_sum(tail_length[adj_dest[k]], {12'd0, node_weight[u]});
        if (c > tail_length[u]) tail_length[u] = c;
      end
    end
    crit_length = '0;
    for (i = 0; i < n; i++)
      if (tail_length[i] > crit_length) crit_length = tail_length[i];
    schedule_stale = 1'b0;
    r.status = edge_lost ? ST_OVERFLOW : ST_OK;
    r.value = edge_lost ? '0 : crit_length;
    return r;
  endfunction

  // applies one transaction; returns 1 when it yields a result
  function automatic bit predict_slack(graph_item_t it, output slack_result_t r);
    logic [33:0] total;
    r = '0;
    case (it.op)
      OP_CLEAR: begin
        edge_count = 0;
        edge_lost = 1'b0;
        crit_length = '0;
        schedule_stale = 1'b1;
        return 1'b0;
      end
      OP_SET_W: begin
        node_weight[it.node] = it.amount;
        return 1'b0;
      end
      OP_ADD_E: begin
        if (edge_count >= EDGE_CAP) edge_lost = 1'b1;
        else begin
          edge_from[edge_count] = it.node;
          edge_to[edge_count] = it.target;
          edge_count++;
        end
        return 1'b0;
      end
      OP_COMPUTE: begin
        r = schedule_graph();
        return 1'b1;
      end
      OP_QUERY: begin
        if (schedule_stale || it.node >= active_nodes()) return 1'b0;
        total = {2'b0, start_time[it.node]} + {2'b0, tail_length[it.node]} +
                {14'd0, it.amount};
        if (total <= {2'b0, crit_length}) r.status = ST_FITS;
        else begin
          r.status = ST_LATE;
          total = total - {2'b0, crit_length};
          r.value = (total > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // input driver and ready generator, both on the falling edge
  always @(negedge clk_i) begin
    graph_item_t nxt;
    if (!in_ch.valid || in_taken) begin
      if (rst_ni && pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_items.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.operation   <= nxt.op;
        in_ch.node_index  <= nxt.node;
        in_ch.target_node <= nxt.target;
        in_ch.amount      <= nxt.amount;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= rst_ni && !hold_ready && ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor: check results, then predict from accepted transactions
  always @(posedge clk_i) begin
    slack_result_t got, want;
    graph_item_t   it;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        got.status = out_ch.status;
        got.value = out_ch.value;
        if (slack_expect.size() == 0) begin
          $error("unexpected result status=%0d value=%0d", got.status, got.value);
          fail_count++;
        end else begin
          want = slack_expect.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            fail_count++;
          end
          if (got.value !== want.value) begin
            $error("value: expected %0d, actual %0d", want.value, got.value);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        it = {in_ch.operation, in_ch.node_index, in_ch.target_node, in_ch.amount};
        if (predict_slack(it, want)) slack_expect = {slack_expect, want};
      end
      in_taken <= in_ch.valid && in_ch.ready;
    end else begin
      in_taken <= 1'b0;
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    wait (pressure_go);
    repeat (40) @(posedge clk_i);
    hold_ready = 1'b1;
    repeat (600) @(posedge clk_i);
    hold_ready = 1'b0;
  end

  // run limit
  initial begin
    #60_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic queue_item(logic [OP_W-1:0] op, int unsigned node, int unsigned target,
                            int unsigned amount);
    graph_item_t it;
    it.op = op;
    it.node = node[IDX_W-1:0];
    it.target = target[IDX_W-1:0];
    it.amount = amount[AMT_W-1:0];
    pending_items = {pending_items, it};
  endtask

  // everything sent and answered, plus the silent query latency
  task automatic wait_quiet();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || in_ch.valid || slack_expect.size() != 0);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_node_count(int unsigned v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v[NC_W-1:0];
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    node_limit = v & 32'h7FF;
    schedule_stale = 1'b1;
  endtask

  function automatic int unsigned pick_amount();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 20'hFFFFF;
      2, 3:    return $urandom_range(0, 1000);
      default: return $urandom_range(0, 20'hFFFFF);
    endcase
  endfunction

  // random well-formed episode: size, clear, weights, edges, compute, queries
  task automatic run_episode();
    int unsigned n, cfg, ecount, s, t, i;
    bit          make_loop;
    case ($urandom_range(19))
      0:       cfg = 0;
      1:       cfg = 1;
      default: cfg = $urandom_range(2, 12);
    endcase
    wait_quiet();
    write_node_count(cfg);
    n = active_nodes();
    queue_item(OP_CLEAR, $urandom_range(1023), $urandom_range(1023), pick_amount());
    random_items++;
    if ($urandom_range(9) == 0) begin
      queue_item(OP_QUERY, $urandom_range(0, n - 1), 0, pick_amount());
      random_items++;
    end
    repeat ($urandom_range(0, 4)) begin
      queue_item(OP_SET_W, $urandom_range(1023), $urandom_range(1023), pick_amount());
      random_items++;
    end
    make_loop = ($urandom_range(7) == 0);
    ecount = $urandom_range(0, 24);
    for (i = 0; i < ecount; i++) begin
      if ($urandom_range(9) == 0) begin
        s = $urandom_range(1023); t = $urandom_range(1023);
      end else if (n >= 2) begin
        s = $urandom_range(0, n - 2); t = $urandom_range(s + 1, n - 1);
      end else begin
        s = 0; t = $urandom_range(1, 1023);
      end
      queue_item(OP_ADD_E, s, t, pick_amount());
      random_items++;
      if ($urandom_range(15) == 0) begin
        queue_item(OP_NOISE_LO + OP_W'($urandom_range(2)), $urandom_range(1023),
                   $urandom_range(1023), pick_amount());
        random_items++;
      end
    end
    if (make_loop) begin
      s = $urandom_range(0, n - 1); t = $urandom_range(0, s);
      queue_item(OP_ADD_E, s, t, 0);
      random_items++;
    end
    queue_item(OP_COMPUTE, $urandom_range(1023), $urandom_range(1023), pick_amount());
    random_items++;
    repeat ($urandom_range(2, 8)) begin
      if ($urandom_range(9) == 0) s = $urandom_range(1023);
      else s = $urandom_range(0, n - 1);
      queue_item(OP_QUERY, s, $urandom_range(1023),
                 ($urandom_range(2) == 0) ? 0 : pick_amount());
      random_items++;
    end
  endtask

  initial begin
    int unsigned i;
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.node_index = '0;
    in_ch.target_node = '0;
    in_ch.amount = '0;
    out_ch.ready = 1'b0;
    node_limit = 1;
    edge_count = 0;
    edge_lost = 1'b0;
    crit_length = '0;
    schedule_stale = 1'b1;
    for (i = 0; i < NODE_CAP; i++) node_weight[i] = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 29;
    recv_idle_pct = 65;

    // silent query before anything is computed, then unknown operations
    queue_item(OP_QUERY, 0, 0, 5);
    queue_item(OP_NOISE_LO, 1023, 1023, 20'hFFFFF);
    queue_item(OP_NOISE_MID, 0, 0, 0);
    queue_item(OP_NOISE_HI, 512, 511, 20'h55555);
    // define every weight so no compute reads an unwritten one
    queue_item(OP_SET_W, 0, 0, 0);
    queue_item(OP_SET_W, 1, 0, 20'hFFFFF);
    for (i = 2; i < NODE_CAP; i++) queue_item(OP_SET_W, i, 0, $urandom_range(0, 20'hFFFFF));
    // single node after reset
    queue_item(OP_COMPUTE, 0, 0, 0);
    queue_item(OP_QUERY, 0, 0, 20'hFFFFF);
    queue_item(OP_QUERY, 1, 0, 0);
    wait_quiet();

    // node count of zero clamps to one
    write_node_count(0);
    queue_item(OP_QUERY, 0, 0, 0);
    queue_item(OP_COMPUTE, 0, 0, 0);
    queue_item(OP_QUERY, 0, 0, 0);
    wait_quiet();

    // widest setting clamps to the full graph; then a self loop
    write_node_count(2047);
    queue_item(OP_CLEAR, 0, 0, 0);
    queue_item(OP_ADD_E, 0, 1023, 0);
    queue_item(OP_ADD_E, 1023, 1, 0);
    queue_item(OP_COMPUTE, 0, 0, 0);
    queue_item(OP_QUERY, 1023, 0, 0);
    queue_item(OP_QUERY, 0, 0, 20'hFFFFF);
    queue_item(OP_ADD_E, 7, 7, 0);
    queue_item(OP_COMPUTE, 0, 0, 0);
    queue_item(OP_QUERY, 7, 0, 0);
    wait_quiet();

    // full node count, edges outside the active range, a longer cycle
    write_node_count(1024);
    queue_item(OP_CLEAR, 0, 0, 0);
    queue_item(OP_ADD_E, 1, 2, 0);
    queue_item(OP_COMPUTE, 0, 0, 0);
    queue_item(OP_QUERY, 2, 0, 3);
    wait_quiet();
    write_node_count(4);
    queue_item(OP_CLEAR, 0, 0, 0);
    queue_item(OP_ADD_E, 0, 900, 0);
    queue_item(OP_ADD_E, 1, 2, 0);
    queue_item(OP_COMPUTE, 0, 0, 0);
    queue_item(OP_ADD_E, 2, 3, 0);
    queue_item(OP_ADD_E, 3, 1, 0);
    queue_item(OP_COMPUTE, 0, 0, 0);
    wait_quiet();

    // random episodes in three idling phases
    pressure_go = 1'b1;
    while (random_items < 680) begin
      if (random_items >= 453) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (random_items >= 227) begin
        send_idle_pct = 65;
        recv_idle_pct = 29;
      end
      run_episode();
    end
    wait_quiet();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/dcp_pkg.sv
rtl/dcp_intf.sv
rtl/dcp_ctrl.sv
rtl/dcp_datapath.sv
rtl/dag_critical_path_slack_check_unit.sv
rtl/dcp_checker.sv
dv/tb.sv
